[hdl/ppr_pkg.sv]
// Package: shared types and constants of the pressure PID regulator.
`default_nettype none

package ppr_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_REGULATE = 2'd0,
        KIND_BYPASS   = 2'd1,
        KIND_RESTART  = 2'd2,
        KIND_IDLE     = 2'd3
    } t_kind;

    // Register indexes
    localparam logic [2:0] REG_INTEGRAL_ON   = 3'd0;
    localparam logic [2:0] REG_COEF_NOW      = 3'd1;
    localparam logic [2:0] REG_COEF_PREV     = 3'd2;
    localparam logic [2:0] REG_COEF_PREV2    = 3'd3;
    localparam logic [2:0] REG_SETPOINT      = 3'd4;
    localparam logic [2:0] REG_ERR_LIMIT_POS = 3'd5;
    localparam logic [2:0] REG_ERR_LIMIT_NEG = 3'd6;
    localparam logic [2:0] REG_OUT_MIN       = 3'd7;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int DRIVE_W = 23;

    // Register reset values
    localparam logic               RST_INTEGRAL_ON = 1'b1;
    localparam logic [15:0]        RST_COEF_NOW    = 16'd17;
    localparam logic signed [15:0] RST_COEF_PREV   = 16'sd2;
    localparam logic [15:0]        RST_COEF_PREV2  = 16'd0;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] measured;
        logic [30:0]        upper_limit;
    } t_in_item;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic signed [31:0] clamped_error;
    } t_out_item;

    typedef struct packed {
        logic               integral_on;
        logic [15:0]        coef_now;
        logic signed [15:0] coef_prev;
        logic [15:0]        coef_prev2;
        logic signed [31:0] setpoint;
        logic [30:0]        err_limit_pos;
        logic [30:0]        err_limit_neg;
        logic [30:0]        out_min;
    } t_cfg;

    // Regulator state: accumulator and error history
    typedef struct packed {
        logic [31:0]        acc;
        logic signed [31:0] err_prev;
        logic signed [31:0] err_prev2;
    } t_state;

endpackage

`default_nettype wire

[hdl/ppr_regs.sv]
// Register file: APB-style write and read access to the regulator settings.
`default_nettype none

module ppr_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ppr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ppr_pkg::DATA_W-1:0]  pwdata,
    output logic      [ppr_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output ppr_pkg::t_cfg                    o_cfg
);

    ppr_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ppr_pkg::ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.integral_on   <= ppr_pkg::RST_INTEGRAL_ON;
            r_cfg.coef_now      <= ppr_pkg::RST_COEF_NOW;
            r_cfg.coef_prev     <= ppr_pkg::RST_COEF_PREV;
            r_cfg.coef_prev2    <= ppr_pkg::RST_COEF_PREV2;
            r_cfg.setpoint      <= '0;
            r_cfg.err_limit_pos <= '0;
            r_cfg.err_limit_neg <= '0;
            r_cfg.out_min       <= '0;
        end else if (wr_en) begin
            case (idx)
                ppr_pkg::REG_INTEGRAL_ON:   r_cfg.integral_on   <= pwdata[0];
                ppr_pkg::REG_COEF_NOW:      r_cfg.coef_now      <= pwdata[15:0];
                ppr_pkg::REG_COEF_PREV:     r_cfg.coef_prev     <= $signed(pwdata[15:0]);
                ppr_pkg::REG_COEF_PREV2:    r_cfg.coef_prev2    <= pwdata[15:0];
                ppr_pkg::REG_SETPOINT:      r_cfg.setpoint      <= $signed(pwdata);
                ppr_pkg::REG_ERR_LIMIT_POS: r_cfg.err_limit_pos <= pwdata[30:0];
                ppr_pkg::REG_ERR_LIMIT_NEG: r_cfg.err_limit_neg <= pwdata[30:0];
                ppr_pkg::REG_OUT_MIN:       r_cfg.out_min       <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            ppr_pkg::REG_INTEGRAL_ON:   prdata = {31'd0, r_cfg.integral_on};
            ppr_pkg::REG_COEF_NOW:      prdata = {16'd0, r_cfg.coef_now};
            ppr_pkg::REG_COEF_PREV:     prdata = {{16{r_cfg.coef_prev[15]}}, r_cfg.coef_prev};
            ppr_pkg::REG_COEF_PREV2:    prdata = {16'd0, r_cfg.coef_prev2};
            ppr_pkg::REG_SETPOINT:      prdata = r_cfg.setpoint;
            ppr_pkg::REG_ERR_LIMIT_POS: prdata = {1'b0, r_cfg.err_limit_pos};
            ppr_pkg::REG_ERR_LIMIT_NEG: prdata = {1'b0, r_cfg.err_limit_neg};
            ppr_pkg::REG_OUT_MIN:       prdata = {1'b0, r_cfg.out_min};
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/ppr_core.sv]
// Core datapath: PID sum, output saturation and state update for one item.
`default_nettype none

module ppr_core #(
    parameter int          SHIFT        = 8,
    parameter logic [31:0] START_OUTPUT = 32'd51200
) (
    input  wire ppr_pkg::t_cfg               i_cfg,
    input  wire logic [1:0]                  i_kind,
    input  wire logic signed [31:0]          i_err,
    input  wire logic [30:0]                 i_upper,
    input  wire ppr_pkg::t_state             i_state,
    output ppr_pkg::t_state                  o_state,
    output logic [ppr_pkg::DRIVE_W-1:0]      o_drive
);

    logic signed [48:0] p_now;
    logic signed [48:0] p_prev;
    logic signed [48:0] p_prev2;
    logic signed [51:0] acc_term;
    logic signed [51:0] sum;
    logic signed [51:0] upper_ext;
    logic signed [51:0] min_ext;
    logic [31:0]        acc_sat;
    logic [31:0]        acc_shifted;

    assign p_now   = $signed({1'b0, i_cfg.coef_now}) * i_err;
    assign p_prev  = i_cfg.coef_prev * i_state.err_prev;
    assign p_prev2 = $signed({1'b0, i_cfg.coef_prev2}) * i_state.err_prev2;

    assign acc_term  = i_cfg.integral_on ? $signed({20'd0, i_state.acc}) : '0;
    assign sum       = acc_term + 52'(p_now) - 52'(p_prev) + 52'(p_prev2);
    assign upper_ext = $signed({21'd0, i_upper});
    assign min_ext   = $signed({21'd0, i_cfg.out_min});

    // When the bounds cross, the upper bound wins for sums above it; lower sums take the lower bound
    always_comb begin
        if (sum > upper_ext) begin
            acc_sat = {1'b0, i_upper};
        end else if (sum < min_ext) begin
            acc_sat = {1'b0, i_cfg.out_min};
        end else begin
            acc_sat = sum[31:0];
        end
    end

    always_comb begin
        o_state = i_state;
        case (ppr_pkg::t_kind'(i_kind))
            ppr_pkg::KIND_REGULATE: begin
                o_state.acc       = acc_sat;
                o_state.err_prev2 = i_state.err_prev;
                o_state.err_prev  = i_err;
            end
            ppr_pkg::KIND_BYPASS: begin
                o_state.acc       = {1'b0, i_upper};
                o_state.err_prev  = '0;
                o_state.err_prev2 = '0;
            end
            ppr_pkg::KIND_RESTART: begin
                o_state.acc       = START_OUTPUT;
                o_state.err_prev  = '0;
                o_state.err_prev2 = '0;
            end
            default: begin
            end
        endcase
    end

    assign acc_shifted = o_state.acc >> SHIFT;
    assign o_drive     = acc_shifted[ppr_pkg::DRIVE_W-1:0];

endmodule

`default_nettype wire

[hdl/pressure_pid_regulator.sv]
// Top level: velocity-form PID pump-speed regulator with APB settings port.
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while i_out_ready is high; the accumulator and error history
//   update in the result stage, so each item sees the state left by the one before it.
// Reset (i_rst_n low, synchronous): both stages empty, accumulator = START_OUTPUT,
//   error history zero, settings at their defaults.
`default_nettype none

module pressure_pid_regulator #(
    parameter int          SHIFT        = 8,
    parameter logic [31:0] START_OUTPUT = 32'd51200
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input items
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire ppr_pkg::t_in_item           i_in_item,
    // result items
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output ppr_pkg::t_out_item               o_out_item,
    // settings port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ppr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ppr_pkg::DATA_W-1:0]  pwdata,
    output logic      [ppr_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    ppr_pkg::t_cfg      cfg;

    // Input stage: kind, clamped error and upper bound of the item
    logic               r_in_valid;
    logic [1:0]         r_kind;
    logic signed [31:0] r_err;
    logic [30:0]        r_upper;

    // Regulator state and result register
    ppr_pkg::t_state    r_state;
    ppr_pkg::t_state    n_state;
    logic               r_out_valid;
    ppr_pkg::t_out_item r_out_item;

    logic               advance;
    logic               accept;
    logic signed [32:0] err_raw;
    logic signed [32:0] lim_pos;
    logic signed [32:0] lim_neg;
    logic signed [31:0] n_err;
    logic [ppr_pkg::DRIVE_W-1:0] n_drive;

    ppr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Advance the input stage whenever the result register is free or being drained.
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;
    assign accept     = i_in_valid & o_in_ready;

    // Error at full precision, clamped to the admitted window, ahead of the input register.
    // Users must hold settings steady while items are in flight; the block does not enforce it.
    assign err_raw = {cfg.setpoint[31], cfg.setpoint}
                   - {i_in_item.measured[31], i_in_item.measured};
    assign lim_pos = $signed({2'b00, cfg.err_limit_pos});
    assign lim_neg = -$signed({2'b00, cfg.err_limit_neg});

    always_comb begin
        if (err_raw > lim_pos) begin
            n_err = lim_pos[31:0];
        end else if (err_raw < lim_neg) begin
            n_err = lim_neg[31:0];
        end else begin
            n_err = err_raw[31:0];
        end
        // Report zero error outside regulate items
        if (ppr_pkg::t_kind'(i_in_item.kind) != ppr_pkg::KIND_REGULATE) begin
            n_err = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Load the input payload only on accept; hold otherwise.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_in_item.kind;
            r_err   <= n_err;
            r_upper <= i_in_item.upper_limit;
        end
    end

    ppr_core #(
        .SHIFT        (SHIFT),
        .START_OUTPUT (START_OUTPUT)
    ) u_core (
        .i_cfg   (cfg),
        .i_kind  (r_kind),
        .i_err   (r_err),
        .i_upper (r_upper),
        .i_state (r_state),
        .o_state (n_state),
        .o_drive (n_drive)
    );

    // Commit the state only when the item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.acc       <= START_OUTPUT;
            r_state.err_prev  <= '0;
            r_state.err_prev2 <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item.drive         <= n_drive;
            r_out_item.clamped_error <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
